### hdl/yuvrgb_pkg.sv
`default_nettype none

package yuvrgb_pkg;

  // Field and register widths
  localparam int SAMPLE_W            = 12;
  localparam int PIXEL_W             = 8;
  localparam int BITS_W              = 4;
  localparam int HEIGHT_W            = 13;
  localparam int CFG_INDEX_W         = 2;
  localparam int CFG_DATA_W          = 13;

  // Sample depth limits
  localparam int MIN_SAMPLE_BITS     = 8;
  localparam int MAX_SAMPLE_BITS_DEF = 12;
  localparam int REG_BITS_MAX        = (1 << BITS_W) - 1;

  // 8-bit reference codes for black level and chroma center
  localparam int BLACK_CODE          = 16;
  localparam int CHROMA_MID_CODE     = 128;

  // Fixed-point formats
  localparam int GAIN_W              = 25;  // unsigned Q1.24 range gain
  localparam int KCOEF_W             = 17;  // unsigned Q1.16 matrix magnitude
  localparam int MCOEF_W             = KCOEF_W + GAIN_W;  // merged coefficient
  localparam int SPLIT_W             = 21;  // low slice of merged coefficient
  localparam int GAIN_IDX_W          = 3;   // effective bits minus eight
  localparam int COEF_FRAC           = 16;
  localparam int OUT_SHIFT           = 40;

  localparam logic [HEIGHT_W-1:0] SD_HEIGHT_LIMIT = HEIGHT_W'(576);

  typedef enum logic [1:0] {
    STD_BT601,
    STD_BT709,
    STD_BT2020,
    STD_AUTO
  } color_std_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COLOR_STD,
    REG_FRAME_HEIGHT,
    REG_FULL_RANGE,
    REG_SAMPLE_BITS
  } cfg_reg_e;

  // Matrix terms: R from Cr, B from Cb, G from Cr, G from Cb
  typedef enum logic [1:0] {
    K_RV,
    K_BU,
    K_GV,
    K_GU
  } coef_sel_e;

  typedef logic [KCOEF_W-1:0] kcoef_t;

  typedef struct packed {
    logic [GAIN_W-1:0] luma;
    logic [GAIN_W-1:0] chroma;
  } gain_pair_t;

  // Q1.16 matrix magnitudes; green terms are subtracted by the datapath.
  function automatic kcoef_t matrix_coef(input color_std_e std_sel, input coef_sel_e sel);
    kcoef_t k;
    k = '0;
    case (std_sel)
      STD_BT709: begin
        case (sel)
          K_RV:    k = KCOEF_W'(103206);
          K_BU:    k = KCOEF_W'(121609);
          K_GV:    k = KCOEF_W'(30679);
          default: k = KCOEF_W'(12276);
        endcase
      end
      STD_BT2020: begin
        case (sel)
          K_RV:    k = KCOEF_W'(96639);
          K_BU:    k = KCOEF_W'(123299);
          K_GV:    k = KCOEF_W'(37444);
          default: k = KCOEF_W'(10784);
        endcase
      end
      default: begin
        case (sel)
          K_RV:    k = KCOEF_W'(91881);
          K_BU:    k = KCOEF_W'(116130);
          K_GV:    k = KCOEF_W'(46802);
          default: k = KCOEF_W'(22553);
        endcase
      end
    endcase
    return k;
  endfunction

  // round(255 * 2^24 / span) for luma and chroma spans, by range and depth
  function automatic gain_pair_t range_gain(input logic full, input logic [GAIN_IDX_W-1:0] idx);
    gain_pair_t g;
    g = '0;
    case ({full, idx})
      4'b0_000: g = '{luma: GAIN_W'(19535115), chroma: GAIN_W'(19099063)};
      4'b0_001: g = '{luma: GAIN_W'(9767557),  chroma: GAIN_W'(9549531)};
      4'b0_010: g = '{luma: GAIN_W'(4883779),  chroma: GAIN_W'(4774766)};
      4'b0_011: g = '{luma: GAIN_W'(2441889),  chroma: GAIN_W'(2387383)};
      4'b0_100: g = '{luma: GAIN_W'(1220945),  chroma: GAIN_W'(1193691)};
      4'b0_101: g = '{luma: GAIN_W'(610472),   chroma: GAIN_W'(596846)};
      4'b0_110: g = '{luma: GAIN_W'(305236),   chroma: GAIN_W'(298423)};
      4'b0_111: g = '{luma: GAIN_W'(152618),   chroma: GAIN_W'(149211)};
      4'b1_000: g = '{luma: GAIN_W'(16777216), chroma: GAIN_W'(16777216)};
      4'b1_001: g = '{luma: GAIN_W'(8372192),  chroma: GAIN_W'(8372192)};
      4'b1_010: g = '{luma: GAIN_W'(4182004),  chroma: GAIN_W'(4182004)};
      4'b1_011: g = '{luma: GAIN_W'(2089980),  chroma: GAIN_W'(2089980)};
      4'b1_100: g = '{luma: GAIN_W'(1044735),  chroma: GAIN_W'(1044735)};
      4'b1_101: g = '{luma: GAIN_W'(522304),   chroma: GAIN_W'(522304)};
      4'b1_110: g = '{luma: GAIN_W'(261136),   chroma: GAIN_W'(261136)};
      default:  g = '{luma: GAIN_W'(130564),   chroma: GAIN_W'(130564)};
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

### hdl/yuv_to_rgb_pixel_converter.sv
`default_nettype none

// Y'CbCr to 8-bit R'G'B' pixel converter. One pixel (luma, Cb, Cr of 8 to
// MAX_SAMPLE_BITS significant bits) enters per clock while the input is not
// stalled; its red, green and blue bytes pass the input register, a multiply
// stage with nine narrow signed multipliers, then a sum/round/clamp stage into
// the result register. Throughput is one pixel per clock when nothing stalls;
// the result register frees itself in the same cycle it is taken, so a waiting
// result never blocks intake unless the downstream stall backs up all three
// stages. Matrix is BT.601, BT.709 or BT.2020, or picked from the frame height
// (BT.709 above 576 lines) when the standard is left unspecified; range is
// full or limited studio swing with offsets 16 and 128 scaled to the sample
// depth. Results are rounded half up and clamped to 0..255. Register writes
// take effect for the next pixel: the input stalls during a register beat
// (the merged coefficients are re-derived from the new values) and after reset
// until coef_ready_q sets. Write registers only with no pixel in flight.
module yuv_to_rgb_pixel_converter #(
  parameter int MAX_SAMPLE_BITS = yuvrgb_pkg::MAX_SAMPLE_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // register write port
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [yuvrgb_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [yuvrgb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // pixel in
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [yuvrgb_pkg::SAMPLE_W-1:0]    luma_sample_i,
  input  wire logic [yuvrgb_pkg::SAMPLE_W-1:0]    cb_sample_i,
  input  wire logic [yuvrgb_pkg::SAMPLE_W-1:0]    cr_sample_i,
  // pixel out
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [yuvrgb_pkg::PIXEL_W-1:0]          red_o,
  output logic [yuvrgb_pkg::PIXEL_W-1:0]          green_o,
  output logic [yuvrgb_pkg::PIXEL_W-1:0]          blue_o
);

  import yuvrgb_pkg::*;

  // Depth register is 4 bits, so the usable depth also tops out there.
  localparam int MaxEffBits = (MAX_SAMPLE_BITS > REG_BITS_MAX) ? REG_BITS_MAX
                                                               : MAX_SAMPLE_BITS;
  // Signed sample difference: raw field or centre offset, whichever is wider
  localparam int DiffW   = ((MAX_SAMPLE_BITS > SAMPLE_W) ? MAX_SAMPLE_BITS : SAMPLE_W) + 1;
  localparam int LumaW   = DiffW + GAIN_W + 1;
  localparam int HiW     = MCOEF_W - SPLIT_W;
  localparam int PartHiW = DiffW + HiW + 1;
  localparam int PartLoW = DiffW + SPLIT_W + 1;
  localparam int SumW    = DiffW + MCOEF_W + 2;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  color_std_e            color_std_q;
  logic [HEIGHT_W-1:0]   frame_height_q;
  logic                  full_range_q;
  logic [BITS_W-1:0]     sample_bits_q;

  logic cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_std_q    <= STD_AUTO;
      frame_height_q <= '0;
      full_range_q   <= 1'b0;
      sample_bits_q  <= BITS_W'(MIN_SAMPLE_BITS);
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_COLOR_STD:    color_std_q    <= color_std_e'(cfg_data_i[1:0]);
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[HEIGHT_W-1:0];
        REG_FULL_RANGE:   full_range_q   <= cfg_data_i[0];
        REG_SAMPLE_BITS:  sample_bits_q  <= cfg_data_i[BITS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Derived constants, re-registered every clock from the config registers.
  // Chroma gain is folded into each matrix term so the pixel path needs no
  // separate gain multiply.
  // ---------------------------------------------------------------------
  logic [BITS_W-1:0]     eff_bits;
  logic [GAIN_IDX_W-1:0] gain_idx;
  color_std_e            std_sel;
  gain_pair_t            gains;

  logic [DiffW-1:0]      y0_d, y0_q;
  logic [DiffW-1:0]      c0_d, c0_q;
  logic [GAIN_W-1:0]     gy_q;
  logic [MCOEF_W-1:0]    kc_d [4];
  logic [MCOEF_W-1:0]    kc_q [4];
  logic                  coef_ready_q;

  always_comb begin
    if (sample_bits_q < BITS_W'(MIN_SAMPLE_BITS)) begin
      eff_bits = BITS_W'(MIN_SAMPLE_BITS);
    end else if (sample_bits_q > BITS_W'(MaxEffBits)) begin
      eff_bits = BITS_W'(MaxEffBits);
    end else begin
      eff_bits = sample_bits_q;
    end
    gain_idx = GAIN_IDX_W'(eff_bits - BITS_W'(MIN_SAMPLE_BITS));

    if (color_std_q == STD_AUTO) begin
      std_sel = (frame_height_q > SD_HEIGHT_LIMIT) ? STD_BT709 : STD_BT601;
    end else begin
      std_sel = color_std_q;
    end

    gains = range_gain(full_range_q, gain_idx);
    y0_d  = full_range_q ? '0 : (DiffW'(BLACK_CODE) << gain_idx);
    c0_d  = DiffW'(CHROMA_MID_CODE) << gain_idx;

    kc_d[K_RV] = MCOEF_W'(matrix_coef(std_sel, K_RV)) * MCOEF_W'(gains.chroma);
    kc_d[K_BU] = MCOEF_W'(matrix_coef(std_sel, K_BU)) * MCOEF_W'(gains.chroma);
    kc_d[K_GV] = MCOEF_W'(matrix_coef(std_sel, K_GV)) * MCOEF_W'(gains.chroma);
    kc_d[K_GU] = MCOEF_W'(matrix_coef(std_sel, K_GU)) * MCOEF_W'(gains.chroma);
  end

  always_ff @(posedge clk_i) begin
    y0_q <= y0_d;
    c0_q <= c0_d;
    gy_q <= gains.luma;
    kc_q <= kc_d;
  end

  // Derived registers hold reset-config values from the first clock on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_ready_q <= 1'b0;
    end else begin
      coef_ready_q <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline flow: each stage moves when the one after it is empty or moving
  // ---------------------------------------------------------------------
  logic s0_valid_q, s1_valid_q, out_valid_q;
  logic ready_s0, ready_s1, ready_out;
  logic in_fire;

  assign ready_out  = !out_valid_q || !out_stall_i;
  assign ready_s1   = !s1_valid_q || ready_out;
  assign ready_s0   = !s0_valid_q || ready_s1;
  assign in_stall_o = !ready_s0 || !coef_ready_q || cfg_valid_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_s0) begin
        s0_valid_q <= in_fire;
      end
      if (ready_s1) begin
        s1_valid_q <= s0_valid_q;
      end
      if (ready_out) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: input register
  // ---------------------------------------------------------------------
  logic [SAMPLE_W-1:0] s0_luma_q, s0_cb_q, s0_cr_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s0_luma_q <= luma_sample_i;
      s0_cb_q   <= cb_sample_i;
      s0_cr_q   <= cr_sample_i;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: offset removal and products. Each merged coefficient is split
  // in two slices so every coefficient multiplier stays near 13 x 22.
  // ---------------------------------------------------------------------
  logic signed [DiffW-1:0]   diff_y, diff_u, diff_v;
  logic signed [DiffW-1:0]   diff_sel [4];
  logic signed [LumaW-1:0]   luma_d, luma_q;
  logic signed [PartHiW-1:0] hi_d [4];
  logic signed [PartHiW-1:0] hi_q [4];
  logic signed [PartLoW-1:0] lo_d [4];
  logic signed [PartLoW-1:0] lo_q [4];

  always_comb begin
    diff_y = $signed(DiffW'(s0_luma_q)) - $signed(y0_q);
    diff_u = $signed(DiffW'(s0_cb_q))   - $signed(c0_q);
    diff_v = $signed(DiffW'(s0_cr_q))   - $signed(c0_q);

    diff_sel[K_RV] = diff_v;
    diff_sel[K_BU] = diff_u;
    diff_sel[K_GV] = diff_v;
    diff_sel[K_GU] = diff_u;

    luma_d = LumaW'(diff_y) * LumaW'($signed({1'b0, gy_q}));
    for (int j = 0; j < 4; j++) begin
      hi_d[j] = PartHiW'(diff_sel[j]) *
                PartHiW'($signed({1'b0, kc_q[j][MCOEF_W-1:SPLIT_W]}));
      lo_d[j] = PartLoW'(diff_sel[j]) *
                PartLoW'($signed({1'b0, kc_q[j][SPLIT_W-1:0]}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_valid_q && ready_s1) begin
      luma_q <= luma_d;
      hi_q   <= hi_d;
      lo_q   <= lo_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: matrix sums (Q.40), round half up, clamp
  // ---------------------------------------------------------------------
  function automatic logic [PIXEL_W-1:0] to_byte(input logic signed [SumW-1:0] acc);
    logic [SumW-1:0]           rnd;
    logic [SumW-OUT_SHIFT-1:0] whole;
    rnd   = $unsigned(acc) + (SumW'(1) << (OUT_SHIFT - 1));
    whole = rnd[SumW-1:OUT_SHIFT];
    if (acc[SumW-1] || (acc == '0)) begin
      return '0;
    end else if (|whole[SumW-OUT_SHIFT-1:PIXEL_W]) begin
      return '1;
    end else begin
      return whole[PIXEL_W-1:0];
    end
  endfunction

  logic signed [SumW-1:0] luma_term;
  logic signed [SumW-1:0] chroma_term [4];
  logic signed [SumW-1:0] sum_r, sum_g, sum_b;
  logic [PIXEL_W-1:0]     red_q, green_q, blue_q;

  always_comb begin
    luma_term = SumW'(luma_q) <<< COEF_FRAC;
    for (int j = 0; j < 4; j++) begin
      chroma_term[j] = (SumW'(hi_q[j]) <<< SPLIT_W) + SumW'(lo_q[j]);
    end
    sum_r = luma_term + chroma_term[K_RV];
    sum_b = luma_term + chroma_term[K_BU];
    sum_g = luma_term - (chroma_term[K_GV] + chroma_term[K_GU]);
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && ready_out) begin
      red_q   <= to_byte(sum_r);
      green_q <= to_byte(sum_g);
      blue_q  <= to_byte(sum_b);
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule

`default_nettype wire

### hdl/yuvrgb_checker.sv
`default_nettype none

module yuvrgb_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           cfg_valid_i,
  input wire logic                           in_valid_i,
  input wire logic                           in_stall_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire logic [yuvrgb_pkg::PIXEL_W-1:0] red_o,
  input wire logic [yuvrgb_pkg::PIXEL_W-1:0] green_o,
  input wire logic [yuvrgb_pkg::PIXEL_W-1:0] blue_o
);

  // stalled result beat stays offered
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // stalled result beat keeps its pixel
  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable({red_o, green_o, blue_o}))
    else $error("result pixel changed while stalled");

  // a pixel taken in must be followed in time by a valid result at the output
  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##3 out_valid_o)
    else $error("accepted pixel did not reach the output in time");

  // no pixel may enter in a register beat
  a_cfg_blocks_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> in_stall_o)
    else $error("pixel accepted during a register write");

  // empty output and no register beat: intake must be open
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !cfg_valid_i && $past(rst_ni) |-> !in_stall_o)
    else $error("input stalled with nothing backing it up");

endmodule

bind yuv_to_rgb_pixel_converter yuvrgb_checker u_checker (.*);

`default_nettype wire

### bench/yuv_to_rgb_pixel_converter_tb.sv
`timescale 1ns / 1ps

module yuv_to_rgb_pixel_converter_tb;
  import yuvrgb_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RESET_LEN   = 11;
  localparam int QUIET_LIMIT = 5000;   // cycles with no beat on any channel
  localparam int DRAIN_WAIT  = 4;      // pipeline is three deep
  localparam int ROUNDS      = 8;      // register settings per idling phase
  localparam int PER_ROUND   = 58;     // pixels per register setting

  typedef struct packed {
    logic [PIXEL_W-1:0] red;
    logic [PIXEL_W-1:0] green;
    logic [PIXEL_W-1:0] blue;
  } rgb_t;

  // Q1.16 matrix terms per standard, indexed by color_std_e (BT.601/709/2020)
  localparam longint K_RED_CR[3]   = '{91881, 103206, 96639};
  localparam longint K_BLUE_CB[3]  = '{116130, 121609, 123299};
  localparam longint K_GREEN_CR[3] = '{46802, 30679, 37444};
  localparam longint K_GREEN_CB[3] = '{22553, 12276, 10784};

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] luma = '0;
  logic [SAMPLE_W-1:0] cb   = '0;
  logic [SAMPLE_W-1:0] cr   = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PIXEL_W-1:0] red;
  logic [PIXEL_W-1:0] green;
  logic [PIXEL_W-1:0] blue;

  yuv_to_rgb_pixel_converter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .luma_sample_i (luma),
    .cb_sample_i   (cb),
    .cr_sample_i   (cr),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .red_o         (red),
    .green_o       (green),
    .blue_o        (blue)
  );

  // Shadow copy of the register file, updated on each accepted register beat.
  // Starts at the reset values.
  color_std_e          std_reg    = STD_AUTO;
  logic [HEIGHT_W-1:0] height_reg = '0;
  logic                full_reg   = 1'b0;
  logic [BITS_W-1:0]   bits_reg   = BITS_W'(8);

  rgb_t pending_rgb[$];   // predicted pixels not yet seen at the output
  rgb_t want;

  int n_errors  = 0;
  int n_pixels  = 0;
  int n_writes  = 0;
  int quiet     = 0;
  int gap_pct   = 0;      // chance per cycle that the sender holds off
  int stall_pct = 0;      // chance per cycle that the receiver stalls

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Receiver side: random stall, changed on the falling edge only.
  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Depth actually used: register value saturated to 8..MAX_SAMPLE_BITS_DEF.
  function automatic int depth_in_use();
    int b;
    b = int'(bits_reg);
    if (b < MIN_SAMPLE_BITS) b = MIN_SAMPLE_BITS;
    if (b > MAX_SAMPLE_BITS_DEF) b = MAX_SAMPLE_BITS_DEF;
    return b;
  endfunction

  // round(255 * 2^24 / span), Q1.24
  function automatic longint unity_gain(longint span);
    return ((longint'(255) <<< 24) + span / 2) / span;
  endfunction

  // Q.40 sum to a byte: non-positive is black, round half up, saturate.
  function automatic logic [PIXEL_W-1:0] round_clamp(longint acc);
    longint q;
    if (acc <= 0) return '0;
    q = (acc + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (q > 255) return 8'd255;
    return q[PIXEL_W-1:0];
  endfunction

  // Expected RGB for one pixel under the current shadow registers.
  function automatic rgb_t convert_pixel(logic [SAMPLE_W-1:0] y, logic [SAMPLE_W-1:0] u_in,
                                         logic [SAMPLE_W-1:0] v_in);
    int         b;
    longint     scale, black, mid, span_y, span_c, gy, gc, l, u, v;
    color_std_e sel;
    rgb_t       px;
    b     = depth_in_use();
    scale = longint'(1) <<< (b - 8);
    mid   = longint'(1) <<< (b - 1);
    if (full_reg) begin
      black  = 0;
      span_y = (longint'(1) <<< b) - 1;
      span_c = span_y;
    end else begin
      black  = BLACK_CODE * scale;
      span_y = 219 * scale;
      span_c = 224 * scale;
    end
    gy = unity_gain(span_y);
    gc = unity_gain(span_c);
    // unspecified standard: HD heights get BT.709, the rest BT.601
    if (std_reg == STD_AUTO) sel = (height_reg > SD_HEIGHT_LIMIT) ? STD_BT709 : STD_BT601;
    else sel = std_reg;
    l = ((longint'(y) - black) * gy) <<< COEF_FRAC;
    u = (longint'(u_in) - mid) * gc;
    v = (longint'(v_in) - mid) * gc;
    px.red   = round_clamp(l + K_RED_CR[sel] * v);
    px.green = round_clamp(l - (K_GREEN_CR[sel] * v + K_GREEN_CB[sel] * u));
    px.blue  = round_clamp(l + K_BLUE_CB[sel] * u);
    return px;
  endfunction

  // Scoreboard: shadow registers, prediction on input beats, checks on output beats.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_e'(cfg_index))
          REG_COLOR_STD:    std_reg    = color_std_e'(cfg_data[1:0]);
          REG_FRAME_HEIGHT: height_reg = cfg_data[HEIGHT_W-1:0];
          REG_FULL_RANGE:   full_reg   = cfg_data[0];
          REG_SAMPLE_BITS:  bits_reg   = cfg_data[BITS_W-1:0];
          default: ;
        endcase
        n_writes++;
      end
      if (in_valid && !in_stall) begin
        pending_rgb.push_back(convert_pixel(luma, cb, cr));
        n_pixels++;
      end
      if (out_valid && !out_stall) begin
        if (pending_rgb.size() == 0) begin
          $error("output beat with no pixel pending: rgb %0d %0d %0d", red, green, blue);
          n_errors++;
        end else begin
          want = pending_rgb.pop_front();
          if (red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, red);
            n_errors++;
          end
          if (green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, green);
            n_errors++;
          end
          if (blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, blue);
            n_errors++;
          end
        end
      end
      // watchdog bookkeeping: any beat on any channel counts as progress
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
  end

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  // One pixel beat. Entered just after a rising edge; returns just after the
  // edge that took the beat, with valid left high for a back-to-back beat.
  task automatic send_pixel(logic [SAMPLE_W-1:0] y, logic [SAMPLE_W-1:0] u_in,
                            logic [SAMPLE_W-1:0] v_in);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    luma     = y;
    cb       = u_in;
    cr       = v_in;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Drop valid and wait for every predicted pixel to come out.
  task automatic drain();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // One register beat; bits above the field are sometimes filled with junk,
  // which the block has to ignore.
  task automatic write_reg(cfg_reg_e idx, int value);
    int fw;
    logic [CFG_DATA_W-1:0] junk;
    case (idx)
      REG_COLOR_STD:    fw = 2;
      REG_FRAME_HEIGHT: fw = HEIGHT_W;
      REG_FULL_RANGE:   fw = 1;
      default:          fw = BITS_W;
    endcase
    junk = ($urandom_range(1) == 1) ? CFG_DATA_W'($urandom) : '0;
    junk = (fw >= CFG_DATA_W) ? '0 : (junk >> fw) << fw;
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_DATA_W'(value) | junk;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(color_std_e std_sel, int height, bit full, int bits);
    drain();
    write_reg(REG_COLOR_STD, int'(std_sel));
    write_reg(REG_FRAME_HEIGHT, height);
    write_reg(REG_FULL_RANGE, int'(full));
    write_reg(REG_SAMPLE_BITS, bits);
  endtask

  // Random sample: mostly inside the active depth, some level landmarks,
  // some raw 12-bit values so every input bit toggles.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int b, top, s, r;
    b   = depth_in_use();
    top = (1 << b) - 1;
    s   = 1 << (b - 8);
    r   = $urandom_range(99);
    if (r < 55) return SAMPLE_W'($urandom_range(top));
    if (r < 75) begin
      case ($urandom_range(5))
        0:       return '0;
        1:       return SAMPLE_W'(top);
        2:       return SAMPLE_W'(BLACK_CODE * s);
        3:       return SAMPLE_W'(235 * s);
        4:       return SAMPLE_W'(240 * s);
        default: return SAMPLE_W'(CHROMA_MID_CODE * s);
      endcase
    end
    return SAMPLE_W'($urandom);
  endfunction

  // Registers left at reset: unspecified standard with height 0 -> BT.601,
  // limited range, 8 bits.
  task automatic test_reset_state();
    send_pixel(12'd0, 12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF, 12'hFFF);
    send_pixel(12'd16, 12'd128, 12'd128);    // black
    send_pixel(12'd235, 12'd128, 12'd128);   // white
    send_pixel(12'd235, 12'd240, 12'd16);
    send_pixel(12'd81, 12'd90, 12'd240);
  endtask

  // Each fixed matrix, then the height rule around the 576-line boundary.
  task automatic test_standards();
    configure(STD_BT601, 0, 1'b0, 8);
    send_pixel(12'd180, 12'd44, 12'd200);
    configure(STD_BT709, 0, 1'b0, 8);
    send_pixel(12'd180, 12'd44, 12'd200);
    configure(STD_BT2020, 8191, 1'b1, 8);
    send_pixel(12'd180, 12'd44, 12'd200);
    configure(STD_AUTO, 576, 1'b0, 8);
    send_pixel(12'd180, 12'd44, 12'd200);
    configure(STD_AUTO, 577, 1'b0, 8);
    send_pixel(12'd180, 12'd44, 12'd200);
    configure(STD_AUTO, 8191, 1'b1, 8);
    send_pixel(12'd180, 12'd44, 12'd200);
  endtask

  // Depth register outside 8..12 saturates; deepest depth in full range.
  task automatic test_sample_depth();
    configure(STD_BT709, 1080, 1'b0, 0);
    send_pixel(12'd255, 12'd0, 12'd255);
    configure(STD_BT601, 480, 1'b1, 7);
    send_pixel(12'd200, 12'd255, 12'd0);
    configure(STD_BT2020, 2160, 1'b0, 15);
    send_pixel(12'd3000, 12'd1024, 12'd3000);
    configure(STD_BT709, 720, 1'b1, 12);
    send_pixel(12'd0, 12'd2048, 12'd2048);
    send_pixel(12'hFFF, 12'd0, 12'hFFF);
    configure(STD_BT601, 0, 1'b0, 13);
    send_pixel(12'd1000, 12'd4000, 12'd100);
  endtask

  // Luma under black and chroma far off center in limited 8-bit range:
  // samples above the 8 significant bits are taken as they stand.
  task automatic test_off_scale();
    configure(STD_BT601, 0, 1'b0, 8);
    send_pixel(12'd0, 12'd255, 12'd0);
    send_pixel(12'd15, 12'd0, 12'd255);
    send_pixel(12'd4000, 12'd300, 12'd4095);
  endtask

  // Random settings and pixels under one idling pattern. First and last
  // settings of each phase sit at the height and usable-depth extremes.
  task automatic test_random_traffic(int sender_gap, int receiver_stall);
    int height, bits;
    color_std_e std_sel;
    bit full;
    gap_pct   = sender_gap;
    stall_pct = receiver_stall;
    for (int r = 0; r < ROUNDS; r++) begin
      if (r == 0) configure(STD_BT601, 0, 1'b0, 8);
      else if (r == ROUNDS - 1) configure(STD_AUTO, 8191, 1'b1, 12);
      else begin
        std_sel = color_std_e'($urandom_range(3));
        case ($urandom_range(4))
          0:       height = 576;
          1:       height = 577;
          2:       height = 0;
          3:       height = 8191;
          default: height = $urandom_range(8191);
        endcase
        full = $urandom_range(1);
        bits = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(12, 8);
        configure(std_sel, height, full, bits);
      end
      for (int i = 0; i < PER_ROUND; i++)
        send_pixel(pick_sample(), pick_sample(), pick_sample());
    end
  endtask

  initial begin
    // async reset held for the first cycles, released on a falling edge
    repeat (RESET_LEN) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_standards();
    test_sample_depth();
    test_off_scale();
    test_random_traffic(0, 0);
    test_random_traffic(76, 0);
    test_random_traffic(0, 76);
    test_random_traffic(23, 23);
    gap_pct   = 0;
    stall_pct = 0;
    drain();

    if (pending_rgb.size() != 0) begin
      $error("%0d predicted pixels never came out", pending_rgb.size());
      n_errors++;
    end
    $display("Converted %0d pixels across %0d register beats: all matrices, both ranges,",
             n_pixels, n_writes);
    $display("depths 0..15 and four sender/receiver idling patterns.");
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/yuvrgb_pkg.sv
hdl/yuv_to_rgb_pixel_converter.sv
hdl/yuvrgb_checker.sv
bench/yuv_to_rgb_pixel_converter_tb.sv
